// ----- hdl/iqws_pkg.sv -----
// shared constants and types of the issue queue wakeup/select block
// no dependencies
package iqws_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PHYS_REGS   = 128;
  localparam int unsigned ARCH_REGS   = 64;
  localparam int unsigned MAX_ISSUE   = 8;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TAG_W       = 7;

  localparam logic [1:0] CMD_DISPATCH = 2'd0;
  localparam logic [1:0] CMD_WAKEUP   = 2'd1;
  localparam logic [1:0] CMD_SELECT   = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ISSUED   = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_WOKEN    = 3'd4;

  typedef struct packed {
    logic [31:0]      pc;
    logic [1:0]       op;
    logic             s1v;
    logic [TAG_W-1:0] s1t;
    logic             s2v;
    logic [TAG_W-1:0] s2t;
    logic             dv;
    logic [TAG_W-1:0] dt;
    logic [15:0]      seq;
    logic [1:0]       rdy;
  } entry_t;

  typedef struct packed {
    logic             write;
    logic             shift;
    logic             wake;
    logic [TAG_W-1:0] wake_tag;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic             more;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

// ----- hdl/iqws_cell.sv -----
// one queue slot: holds an entry, takes its upper neighbor on a collapse
// depends on iqws_pkg
module iqws_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iqws_pkg::cell_ctl_t ctl_i,
  input  iqws_pkg::entry_t   new_i,
  input  logic               up_valid_i,
  input  iqws_pkg::entry_t   up_entry_i,
  output logic               valid_o,
  output iqws_pkg::entry_t   entry_o
);

  logic             valid_q, valid_d;
  iqws_pkg::entry_t entry_q, entry_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctl_i.shift) begin
      valid_d = up_valid_i;
      entry_d = up_entry_i;
    end else if (ctl_i.write) begin
      valid_d = 1'b1;
      entry_d = new_i;
    end else if (ctl_i.wake && valid_q) begin
      if (entry_q.s1v && entry_q.s1t == ctl_i.wake_tag) entry_d.rdy[0] = 1'b1;
      if (entry_q.s2v && entry_q.s2t == ctl_i.wake_tag) entry_d.rdy[1] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ----- hdl/iqws_pick.sv -----
// oldest-first search for an entry with both sources ready
// depends on iqws_pkg
module iqws_pick (
  input  logic [iqws_pkg::QUEUE_DEPTH-1:0] cand_i,
  output iqws_pkg::pick_t                  pick_o
);

  always_comb begin
    pick_o.found = |cand_i;
    pick_o.more  = ($countones(cand_i) > 1);
    pick_o.idx   = '0;
    for (int i = iqws_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (cand_i[i]) pick_o.idx = iqws_pkg::IDX_W'(i);
    end
  end

endmodule

// ----- hdl/issue_queue_wakeup_select.sv -----
// collapsing issue queue with wakeup and oldest-first select
// depends on iqws_pkg, iqws_cell, iqws_pick
// dispatch and wakeup: result in the output register in the cycle after the transfer
// select: the state register enters select, then the output register takes each pick:
//   one issued entry per cycle (up to issue_width) while the receiver keeps up; nothing
//   ready gives a single result; the single-port pick over the cell row sets this rate
// input is held off for the whole select and while a result waits unaccepted
// reset: queue empty, tags below ARCH_REGS ready, issue_width 4
module issue_queue_wakeup_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] pc_i,
  input  logic [1:0]  op_class_i,
  input  logic        src1_valid_i,
  input  logic [6:0]  src1_tag_i,
  input  logic        src2_valid_i,
  input  logic [6:0]  src2_tag_i,
  input  logic        dst_valid_i,
  input  logic [6:0]  dst_tag_i,
  input  logic [15:0] seq_num_i,
  input  logic [6:0]  wake_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_pc_o,
  output logic [1:0]  out_op_class_o,
  output logic        out_src1_valid_o,
  output logic [6:0]  out_src1_tag_o,
  output logic        out_src2_valid_o,
  output logic [6:0]  out_src2_tag_o,
  output logic        out_dst_valid_o,
  output logic [6:0]  out_dst_tag_o,
  output logic [15:0] out_seq_num_o,
  output logic        last_o
);

  localparam int unsigned DEPTH = iqws_pkg::QUEUE_DEPTH;

  typedef enum logic {S_IDLE, S_SEL} state_e;

  state_e                         state_q;
  logic [3:0]                     width_q;
  logic [3:0]                     issued_q;
  logic [iqws_pkg::OCC_W-1:0]     occ_q;
  logic [iqws_pkg::PHYS_REGS-1:0] tag_rdy_q;

  // output register
  logic                           out_valid_q;
  logic [2:0]                     status_q;
  iqws_pkg::entry_t               out_entry_q;
  logic                           last_q;

  logic                           in_xfer, out_free, full, out_load;
  logic [3:0]                     width_eff;
  iqws_pkg::entry_t               new_entry;
  iqws_pkg::cell_ctl_t            ctl [DEPTH];
  logic [DEPTH-1:0]               cell_valid;
  iqws_pkg::entry_t               cell_entry [DEPTH];
  logic [DEPTH-1:0]               cand;
  iqws_pkg::pick_t                pick;
  logic                           sel_step;

  // issue_width of zero acts as one, above eight as eight
  assign width_eff = (width_q == 4'd0) ? 4'd1 :
                     (width_q > 4'(iqws_pkg::MAX_ISSUE)) ? 4'(iqws_pkg::MAX_ISSUE) : width_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (occ_q == iqws_pkg::OCC_W'(DEPTH));
  assign sel_step   = (state_q == S_SEL) && out_free && pick.found;
  // a new result enters the output register this cycle
  assign out_load   = (in_xfer && (command_i == iqws_pkg::CMD_DISPATCH ||
                                   command_i == iqws_pkg::CMD_WAKEUP)) ||
                      ((state_q == S_SEL) && out_free);

  // new entry: destination cleared before the sources look up the table
  always_comb begin
    new_entry.pc  = pc_i;
    new_entry.op  = op_class_i;
    new_entry.s1v = src1_valid_i;
    new_entry.s1t = src1_tag_i;
    new_entry.s2v = src2_valid_i;
    new_entry.s2t = src2_tag_i;
    new_entry.dv  = dst_valid_i;
    new_entry.dt  = dst_tag_i;
    new_entry.seq = seq_num_i;
    new_entry.rdy[0] = !src1_valid_i ||
                       (tag_rdy_q[src1_tag_i] && !(dst_valid_i && dst_tag_i == src1_tag_i));
    new_entry.rdy[1] = !src2_valid_i ||
                       (tag_rdy_q[src2_tag_i] && !(dst_valid_i && dst_tag_i == src2_tag_i));
  end

  // per-cell control: write at the tail, collapse at and above the picked slot, wake every cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].write    = in_xfer && command_i == iqws_pkg::CMD_DISPATCH && !full &&
                        occ_q == iqws_pkg::OCC_W'(i);
      ctl[i].shift    = sel_step && (iqws_pkg::IDX_W'(i) >= pick.idx);
      ctl[i].wake     = in_xfer && command_i == iqws_pkg::CMD_WAKEUP;
      ctl[i].wake_tag = wake_tag_i;
      cand[i]         = cell_valid[i] && (cell_entry[i].rdy == 2'b11);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_top
      iqws_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl[g]),
        .new_i      (new_entry),
        .up_valid_i (1'b0),
        .up_entry_i (cell_entry[g]),
        .valid_o    (cell_valid[g]),
        .entry_o    (cell_entry[g])
      );
    end else begin : g_mid
      iqws_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl[g]),
        .new_i      (new_entry),
        .up_valid_i (cell_valid[g+1]),
        .up_entry_i (cell_entry[g+1]),
        .valid_o    (cell_valid[g]),
        .entry_o    (cell_entry[g])
      );
    end
  end

  iqws_pick u_pick (
    .cand_i (cand),
    .pick_o (pick)
  );

  // control, ready table and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 4'd4;
      issued_q    <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < iqws_pkg::PHYS_REGS; i++) begin
        tag_rdy_q[i] <= (i < iqws_pkg::ARCH_REGS);
      end
    end else begin
      if (cfg_we_i) width_q <= cfg_data_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            case (command_i)
              iqws_pkg::CMD_DISPATCH: begin
                if (!full) begin
                  if (dst_valid_i) tag_rdy_q[dst_tag_i] <= 1'b0;
                  occ_q <= occ_q + 1'b1;
                end
              end
              iqws_pkg::CMD_WAKEUP: begin
                tag_rdy_q[wake_tag_i] <= 1'b1;
              end
              iqws_pkg::CMD_SELECT: begin
                state_q  <= S_SEL;
                issued_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SEL: begin
          if (out_free) begin
            if (pick.found) begin
              occ_q    <= occ_q - 1'b1;
              issued_q <= issued_q + 1'b1;
              if (!pick.more || issued_q + 4'd1 == width_eff) state_q <= S_IDLE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer) begin
      out_entry_q <= '0;
      last_q      <= 1'b1;
      status_q    <= (command_i == iqws_pkg::CMD_WAKEUP) ? iqws_pkg::ST_WOKEN :
                     full ? iqws_pkg::ST_FULL : iqws_pkg::ST_ACCEPTED;
    end else if (state_q == S_SEL && out_free) begin
      if (pick.found) begin
        out_entry_q <= cell_entry[pick.idx];
        status_q    <= iqws_pkg::ST_ISSUED;
        last_q      <= !pick.more || (issued_q + 4'd1 == width_eff);
      end else begin
        out_entry_q <= '0;
        status_q    <= iqws_pkg::ST_NONE;
        last_q      <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_pc_o         = out_entry_q.pc;
  assign out_op_class_o   = out_entry_q.op;
  assign out_src1_valid_o = out_entry_q.s1v;
  assign out_src1_tag_o   = out_entry_q.s1t;
  assign out_src2_valid_o = out_entry_q.s2v;
  assign out_src2_tag_o   = out_entry_q.s2t;
  assign out_dst_valid_o  = out_entry_q.dv;
  assign out_dst_tag_o    = out_entry_q.dt;
  assign out_seq_num_o    = out_entry_q.seq;
  assign last_o           = last_q;

  // valid cells always form a packed run from slot 0; checked here by count against occ_q
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == occ_q) else $error("occupancy mismatch");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= iqws_pkg::OCC_W'(DEPTH)) else $error("occupancy overflow");
  a_sel_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEL |-> !in_ready_o) else $error("input taken during select");
  a_issue_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEL |-> issued_q < width_eff) else $error("issued beyond width");

endmodule
